/* src/csv_field_tokenizer_defines.svh */
// Assertion macros used by the tokenizer module.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Clocked property with the reset masked out.
`define CSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define CSV_ASSERT_NEVER(lbl, cond, msg) \
  `CSV_ASSERT(lbl, !(cond), msg)

`endif

/* src/csvtok_pkg.sv */
package csvtok_pkg;

  // Sizes of the line buffer limits.
  localparam int FIELD_BYTES = 4096;
  localparam int MAX_COLUMNS = 64;

  // Field widths of the result word.
  localparam int LEN_W = 12;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;

  // Character codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Register map.
  localparam logic [2:0] ADDR_COLUMN_LIMIT = 3'd0;
  localparam logic [CNT_W-1:0] COLUMN_LIMIT_RESET = CNT_W'(MAX_COLUMNS);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic {
    ERR_TOO_LONG    = 1'b0,
    ERR_TOO_MANY    = 1'b1
  } err_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] field_index;
    logic [LEN_W-1:0] byte_position;
    logic [LEN_W-1:0] trimmed_length;
    logic             last_of_row;
    logic [CNT_W-1:0] fields_in_row;
    err_e             error_code;
  } result_t;

  // Whitespace that is trimmed at both ends of a field.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

/* src/csv_field_tokenizer.sv */
// Channel   Direction  Word                 Handshake
// input     in         char_code            in_valid_i / in_stall_o
// output    out        kind .. error_code   out_valid_o / out_stall_i
// config    in/out     column_limit         APB write at address 0
//
// One character is taken every cycle unless the input stalls; its result,
// if any, is registered for output. The tokenizer state updates in one pass.
// A skid register holds one more result; it fills when a result arrives while
// the output is stalled, and the input stalls in every cycle it stays full.
// Reset clears the row state and sets column_limit to 64.
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [5:0]  field_index_o,
  output logic [11:0] byte_position_o,
  output logic [11:0] trimmed_length_o,
  output logic        last_of_row_o,
  output logic [6:0]  fields_in_row_o,
  output logic        error_code_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEN_W = csvtok_pkg::LEN_W;
  localparam int CNT_W = csvtok_pkg::CNT_W;
  localparam int IDX_W = csvtok_pkg::IDX_W;

  // Tokenizer state.
  logic             quoted_q, quoted_d;
  logic             quote_pending_q, quote_pending_d;
  logic [CNT_W-1:0] field_counter_q, field_counter_d;
  logic [LEN_W-1:0] raw_length_q, raw_length_d;
  logic             content_started_q, content_started_d;
  logic [LEN_W-1:0] emitted_length_q, emitted_length_d;
  logic [LEN_W-1:0] kept_length_q, kept_length_d;
  logic             row_closed_q, row_closed_d;
  logic [CNT_W-1:0] column_limit_q;

  // Output and skid registers.
  logic                 out_valid_q, skid_valid_q;
  csvtok_pkg::result_t  out_q, skid_q;

  csvtok_pkg::result_t  res;
  logic                 res_valid;
  logic                 in_accept, out_fire;
  logic [CNT_W-1:0]     limit;
  logic                 do_add, do_end, plain, clr_field, clr_row, blank;
  logic [7:0]           c;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign c          = char_code_i;
  assign blank      = csvtok_pkg::is_blank(char_code_i);

  // Effective column limit, capped at the field capacity.
  assign limit = (column_limit_q > CNT_W'(csvtok_pkg::MAX_COLUMNS))
               ? CNT_W'(csvtok_pkg::MAX_COLUMNS) : column_limit_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == csvtok_pkg::ADDR_COLUMN_LIMIT)
                ? {{(32-CNT_W){1'b0}}, column_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_limit_q <= csvtok_pkg::COLUMN_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == csvtok_pkg::ADDR_COLUMN_LIMIT) begin
      column_limit_q <= pwdata[CNT_W-1:0];
    end
  end

  // Per-character state update and result.
  always_comb begin
    quoted_d          = quoted_q;
    quote_pending_d   = quote_pending_q;
    field_counter_d   = field_counter_q;
    raw_length_d      = raw_length_q;
    content_started_d = content_started_q;
    emitted_length_d  = emitted_length_q;
    kept_length_d     = kept_length_q;
    row_closed_d      = row_closed_q;
    res_valid         = 1'b0;
    do_add            = 1'b0;
    do_end            = 1'b0;
    plain             = 1'b0;
    clr_field         = 1'b0;
    clr_row           = 1'b0;
    res               = '0;
    res.kind          = csvtok_pkg::KIND_BYTE;
    res.error_code    = csvtok_pkg::ERR_TOO_LONG;
    res.field_index   = field_counter_q[IDX_W-1:0];
    res.fields_in_row = field_counter_q;

    // Quote handling selects which path the character takes.
    if (row_closed_q) begin
      if (c == csvtok_pkg::CH_NUL) begin
        clr_row = 1'b1;
      end
    end else if (quote_pending_q) begin
      quote_pending_d = 1'b0;
      if (c == csvtok_pkg::CH_QUOTE) begin
        do_add = 1'b1;
      end else begin
        quoted_d = 1'b0;
        plain    = 1'b1;
      end
    end else if (quoted_q) begin
      if (c == csvtok_pkg::CH_QUOTE) begin
        quote_pending_d = 1'b1;
      end else if (c == csvtok_pkg::CH_NUL) begin
        // Unterminated quote: the open field is dropped.
        res_valid       = 1'b1;
        res.kind        = csvtok_pkg::KIND_ROW;
        res.last_of_row = 1'b1;
        clr_row         = 1'b1;
      end else begin
        do_add = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain) begin
      if (c == csvtok_pkg::CH_QUOTE) begin
        quoted_d = 1'b1;
      end else if (c == csvtok_pkg::CH_COMMA || c == csvtok_pkg::CH_NUL ||
                   c == csvtok_pkg::CH_LF || c == csvtok_pkg::CH_CR) begin
        do_end = 1'b1;
      end else begin
        do_add = 1'b1;
      end
    end

    // Content byte with length overflow check, skipping leading whitespace.
    if (do_add) begin
      if (raw_length_q == LEN_W'(csvtok_pkg::FIELD_BYTES - 1)) begin
        res_valid       = 1'b1;
        res.kind        = csvtok_pkg::KIND_ERROR;
        res.last_of_row = 1'b1;
        clr_field       = 1'b1;
        row_closed_d    = 1'b1;
      end else begin
        raw_length_d = raw_length_q + LEN_W'(1);
        if (content_started_q || !blank) begin
          content_started_d = 1'b1;
          emitted_length_d  = emitted_length_q + LEN_W'(1);
          if (!blank) begin
            kept_length_d = emitted_length_q + LEN_W'(1);
          end
          res_valid         = 1'b1;
          res.data_byte     = c;
          res.byte_position = emitted_length_q;
        end
      end
    end

    // Field end with column check.
    if (do_end) begin
      res_valid = 1'b1;
      if (field_counter_q >= limit) begin
        res.kind        = csvtok_pkg::KIND_ERROR;
        res.error_code  = csvtok_pkg::ERR_TOO_MANY;
        res.last_of_row = 1'b1;
        if (c == csvtok_pkg::CH_NUL) begin
          clr_row = 1'b1;
        end else begin
          clr_field    = 1'b1;
          row_closed_d = 1'b1;
        end
      end else begin
        res.kind           = csvtok_pkg::KIND_FIELD;
        res.trimmed_length = kept_length_q;
        res.last_of_row    = (c == csvtok_pkg::CH_NUL) || (c == csvtok_pkg::CH_LF);
        res.fields_in_row  = field_counter_q + CNT_W'(1);
        field_counter_d    = field_counter_q + CNT_W'(1);
        if (c == csvtok_pkg::CH_NUL) begin
          clr_row = 1'b1;
        end else begin
          clr_field = 1'b1;
          if (c == csvtok_pkg::CH_LF) begin
            row_closed_d = 1'b1;
          end
        end
      end
    end

    // Clearing the field, and for a new row the counters too.
    if (clr_field || clr_row) begin
      quoted_d          = 1'b0;
      quote_pending_d   = 1'b0;
      raw_length_d      = '0;
      content_started_d = 1'b0;
      emitted_length_d  = '0;
      kept_length_d     = '0;
    end
    if (clr_row) begin
      field_counter_d = '0;
      row_closed_d    = 1'b0;
    end
  end

  // State registers advance on each accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q          <= 1'b0;
      quote_pending_q   <= 1'b0;
      field_counter_q   <= '0;
      raw_length_q      <= '0;
      content_started_q <= 1'b0;
      emitted_length_q  <= '0;
      kept_length_q     <= '0;
      row_closed_q      <= 1'b0;
    end else if (in_accept) begin
      quoted_q          <= quoted_d;
      quote_pending_q   <= quote_pending_d;
      field_counter_q   <= field_counter_d;
      raw_length_q      <= raw_length_d;
      content_started_q <= content_started_d;
      emitted_length_q  <= emitted_length_d;
      kept_length_q     <= kept_length_d;
      row_closed_q      <= row_closed_d;
    end
  end

  // Output register with a one-word skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign field_index_o    = out_q.field_index;
  assign byte_position_o  = out_q.byte_position;
  assign trimmed_length_o = out_q.trimmed_length;
  assign last_of_row_o    = out_q.last_of_row;
  assign fields_in_row_o  = out_q.fields_in_row;
  assign error_code_o     = out_q.error_code;

  // Checks on the skid stage and the tokenizer state.
  `CSV_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full while output empty")
  `CSV_ASSERT(a_skid_catch, in_accept && res_valid && out_valid_q && out_stall_i |=> skid_valid_q, "lost result")
  `CSV_ASSERT(a_pending_quoted, quote_pending_q |-> quoted_q, "pending quote outside quotes")
  `CSV_ASSERT_NEVER(a_count_range, field_counter_q > CNT_W'(csvtok_pkg::MAX_COLUMNS), "count too high")
  `CSV_ASSERT(a_kept_order, kept_length_q <= emitted_length_q, "kept length above emitted")
  `CSV_ASSERT(a_emit_order, emitted_length_q <= raw_length_q, "emitted length above raw")

endmodule

/* test/csv_field_tokenizer_test.sv */
`timescale 1ns / 1ps

module csv_field_tokenizer_test;

  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_CHARS = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_code_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [5:0]  field_index_o;
  logic [11:0] byte_position_o;
  logic [11:0] trimmed_length_o;
  logic        last_of_row_o;
  logic [6:0]  fields_in_row_o;
  logic        error_code_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  csv_field_tokenizer u_dut (.*);

  // Tracks the tokenizer state of the current row and the results still owed.
  class csv_line_checker;
    logic [6:0]           col_limit;
    bit                   quote_open;
    bit                   quote_wait;
    bit                   text_started;
    bit                   row_done;
    int unsigned          row_fields;
    int unsigned          raw_len;
    int unsigned          out_len;
    int unsigned          kept_len;
    csvtok_pkg::result_t  pending_tokens[$];
    int unsigned          failures;
    int unsigned          all_chars;
    int unsigned          live_chars;
    int unsigned          kinds_seen[4];

    function new();
      col_limit = csvtok_pkg::COLUMN_LIMIT_RESET;
      clear_row();
    endfunction

    function void set_limit(logic [6:0] value);
      col_limit = value;
    endfunction

    function bit blank(logic [7:0] c);
      return c == csvtok_pkg::CH_SPACE || c == csvtok_pkg::CH_TAB ||
             c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF;
    endfunction

    function void clear_field();
      quote_open = 0;
      quote_wait = 0;
      raw_len = 0;
      text_started = 0;
      out_len = 0;
      kept_len = 0;
    endfunction

    function void clear_row();
      clear_field();
      row_fields = 0;
      row_done = 0;
    endfunction

    function void emit(csvtok_pkg::kind_e k, logic [7:0] data, int unsigned pos,
                       int unsigned tlen, bit closes, int unsigned done,
                       csvtok_pkg::err_e err);
      csvtok_pkg::result_t r;
      r.kind = k;
      r.data_byte = data;
      r.field_index = csvtok_pkg::IDX_W'(row_fields);
      r.byte_position = csvtok_pkg::LEN_W'(pos);
      r.trimmed_length = csvtok_pkg::LEN_W'(tlen);
      r.last_of_row = closes;
      r.fields_in_row = csvtok_pkg::CNT_W'(done);
      r.error_code = err;
      pending_tokens.push_back(r);
    endfunction

    // A byte of the field: overflow check, leading blank skip, trailing trim.
    function void add_char(logic [7:0] c);
      if (raw_len + 1 >= csvtok_pkg::FIELD_BYTES) begin
        emit(csvtok_pkg::KIND_ERROR, 8'h00, 0, 0, 1'b1, row_fields,
             csvtok_pkg::ERR_TOO_LONG);
        clear_field();
        row_done = 1;
        return;
      end
      raw_len++;
      if (!text_started && blank(c)) return;
      text_started = 1;
      emit(csvtok_pkg::KIND_BYTE, c, out_len, 0, 1'b0, row_fields,
           csvtok_pkg::ERR_TOO_LONG);
      out_len++;
      if (!blank(c)) kept_len = out_len;
    endfunction

    // A separator or end byte closes the field, unless the row is full.
    function void end_field(logic [7:0] c);
      int unsigned cap;
      cap = (col_limit > csvtok_pkg::MAX_COLUMNS) ? csvtok_pkg::MAX_COLUMNS : col_limit;
      if (row_fields >= cap) begin
        emit(csvtok_pkg::KIND_ERROR, 8'h00, 0, 0, 1'b1, row_fields,
             csvtok_pkg::ERR_TOO_MANY);
        if (c == csvtok_pkg::CH_NUL) begin
          clear_row();
        end else begin
          clear_field();
          row_done = 1;
        end
        return;
      end
      emit(csvtok_pkg::KIND_FIELD, 8'h00, 0, kept_len,
           c == csvtok_pkg::CH_NUL || c == csvtok_pkg::CH_LF, row_fields + 1,
           csvtok_pkg::ERR_TOO_LONG);
      row_fields++;
      if (c == csvtok_pkg::CH_NUL) begin
        clear_row();
      end else begin
        clear_field();
        if (c == csvtok_pkg::CH_LF) row_done = 1;
      end
    endfunction

    // Called for every accepted character word.
    function void tokenize_char(logic [7:0] c);
      all_chars++;
      if (row_done) begin
        if (c == csvtok_pkg::CH_NUL) clear_row();
        return;
      end
      live_chars++;
      if (quote_wait) begin
        quote_wait = 0;
        if (c == csvtok_pkg::CH_QUOTE) begin
          add_char(c);
          return;
        end
        quote_open = 0;
      end else if (quote_open) begin
        if (c == csvtok_pkg::CH_QUOTE) begin
          quote_wait = 1;
          return;
        end
        if (c == csvtok_pkg::CH_NUL) begin
          emit(csvtok_pkg::KIND_ROW, 8'h00, 0, 0, 1'b1, row_fields,
               csvtok_pkg::ERR_TOO_LONG);
          clear_row();
          return;
        end
        add_char(c);
        return;
      end
      if (c == csvtok_pkg::CH_QUOTE) begin
        quote_open = 1;
        return;
      end
      if (c == csvtok_pkg::CH_COMMA || c == csvtok_pkg::CH_NUL ||
          c == csvtok_pkg::CH_LF || c == csvtok_pkg::CH_CR) end_field(c);
      else add_char(c);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        failures++;
      end
    endfunction

    // Called for every accepted result word.
    function void check_token(csvtok_pkg::result_t got);
      csvtok_pkg::result_t want;
      if (pending_tokens.size() == 0) begin
        $error("result with nothing expected: kind %0d, field_index %0d",
               got.kind, got.field_index);
        failures++;
        return;
      end
      want = pending_tokens.pop_front();
      kinds_seen[want.kind]++;
      compare("kind", want.kind, got.kind);
      compare("data_byte", want.data_byte, got.data_byte);
      compare("field_index", want.field_index, got.field_index);
      compare("byte_position", want.byte_position, got.byte_position);
      compare("trimmed_length", want.trimmed_length, got.trimmed_length);
      compare("last_of_row", want.last_of_row, got.last_of_row);
      compare("fields_in_row", want.fields_in_row, got.fields_in_row);
      compare("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  csv_line_checker board;
  logic [7:0]      line_q[$];
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  bit              hold_request;
  int unsigned     hold_left;
  int unsigned     stuck_cycles;

  // Clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random stalls, or one long hold when asked for.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watch both channels; predict on each input word, check each result word.
  always @(posedge clk_i) begin
    csvtok_pkg::result_t got;
    bit                  moved;
    if (rst_ni) begin
      moved = 0;
      if (in_valid_i && !in_stall_o) begin
        board.tokenize_char(char_code_i);
        moved = 1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.kind = csvtok_pkg::kind_e'(kind_o);
        got.data_byte = data_byte_o;
        got.field_index = field_index_o;
        got.byte_position = byte_position_o;
        got.trimmed_length = trimmed_length_o;
        got.last_of_row = last_of_row_o;
        got.fields_in_row = fields_in_row_o;
        got.error_code = csvtok_pkg::err_e'(error_code_o);
        board.check_token(got);
        moved = 1;
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // Watchdog on handshake progress.
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $error("no word moved for %0d cycles", STUCK_LIMIT);
    $display("csv_field_tokenizer test failed");
    $finish;
  end

  // Random field byte; never a separator, a quote, or (unless asked) a blank.
  function automatic logic [7:0] pick_char(bit with_blanks);
    logic [7:0] c;
    if (with_blanks && $urandom_range(7) == 0)
      return $urandom_range(1) ? csvtok_pkg::CH_SPACE : csvtok_pkg::CH_TAB;
    do c = 8'($urandom_range(1, 255));
    while (c == csvtok_pkg::CH_COMMA || c == csvtok_pkg::CH_QUOTE ||
           c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF ||
           c == csvtok_pkg::CH_SPACE || c == csvtok_pkg::CH_TAB);
    return c;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(2))
      line_q.push_back($urandom_range(1) ? csvtok_pkg::CH_SPACE : csvtok_pkg::CH_TAB);
  endfunction

  // A row of random plain and quoted fields, at times past the column limit.
  function automatic void build_row(int unsigned cols);
    int unsigned nfields;
    int unsigned len;
    nfields = ($urandom_range(9) == 0) ? $urandom_range(1, cols + 2) : $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      push_blanks();
      len = (nfields > 6) ? $urandom_range(2) : $urandom_range(8);
      if ($urandom_range(2) == 0) begin
        line_q.push_back(csvtok_pkg::CH_QUOTE);
        repeat (len) begin
          case ($urandom_range(7))
            0: begin
              line_q.push_back(csvtok_pkg::CH_QUOTE);
              line_q.push_back(csvtok_pkg::CH_QUOTE);
            end
            1: begin
              case ($urandom_range(2))
                0: line_q.push_back(csvtok_pkg::CH_COMMA);
                1: line_q.push_back(csvtok_pkg::CH_CR);
                default: line_q.push_back(csvtok_pkg::CH_LF);
              endcase
            end
            default: line_q.push_back(pick_char(1));
          endcase
        end
        line_q.push_back(csvtok_pkg::CH_QUOTE);
        // Text right after the closing quote ends the quoting.
        if ($urandom_range(3) == 0) line_q.push_back(pick_char(0));
      end else begin
        repeat (len) line_q.push_back(pick_char(1));
      end
      push_blanks();
      if (f + 1 < nfields) line_q.push_back(csvtok_pkg::CH_COMMA);
    end
    case ($urandom_range(9))
      6, 7: begin
        line_q.push_back(csvtok_pkg::CH_CR);
        line_q.push_back(csvtok_pkg::CH_LF);
        repeat ($urandom_range(3)) line_q.push_back(8'($urandom_range(1, 255)));
        line_q.push_back(csvtok_pkg::CH_NUL);
      end
      8: begin
        line_q.push_back(csvtok_pkg::CH_LF);
        repeat ($urandom_range(3)) line_q.push_back(8'($urandom_range(1, 255)));
        line_q.push_back(csvtok_pkg::CH_NUL);
      end
      9: begin
        line_q.push_back(csvtok_pkg::CH_CR);
        line_q.push_back(csvtok_pkg::CH_NUL);
      end
      default: line_q.push_back(csvtok_pkg::CH_NUL);
    endcase
  endfunction

  // Loose bytes with many control characters, then an end byte.
  function automatic void build_noise();
    logic [7:0] marks[7];
    marks = '{csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_SPACE,
              csvtok_pkg::CH_TAB, csvtok_pkg::CH_CR, csvtok_pkg::CH_LF,
              csvtok_pkg::CH_NUL};
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(1) == 0) line_q.push_back(marks[$urandom_range(6)]);
      else line_q.push_back(8'($urandom_range(255)));
    end
    line_q.push_back(csvtok_pkg::CH_NUL);
  endfunction

  // Offer one character word and hold it until taken; then maybe go idle.
  task automatic send_char(input logic [7:0] c);
    in_valid_i <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_char(line_q.pop_front());
  endtask

  // Stop sending and let every owed result come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_limit(value[6:0]);
  endtask

  initial begin
    int unsigned cols;
    int unsigned goal;
    board = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    char_code_i <= 8'h00;
    out_stall_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Leading blank skipped, extreme byte kept, trailing blank trimmed.
    push_text(" a");
    line_q.push_back(8'hFF);
    push_text(" ,");
    // Doubled quote inside quotes, then a closing quote followed by text.
    push_text("\"x\"\"y\"z");
    // CR closes a field and the LF after it closes an empty one and the row.
    line_q.push_back(csvtok_pkg::CH_CR);
    line_q.push_back(csvtok_pkg::CH_LF);
    // Bytes of a closed row are dropped up to the end byte.
    push_text("q");
    line_q.push_back(8'h01);
    line_q.push_back(csvtok_pkg::CH_NUL);
    // A quote still open at the end byte drops the field.
    line_q.push_back(csvtok_pkg::CH_QUOTE);
    line_q.push_back(8'h7F);
    line_q.push_back(8'h80);
    line_q.push_back(csvtok_pkg::CH_NUL);
    // A field of blanks only.
    line_q.push_back(csvtok_pkg::CH_TAB);
    line_q.push_back(csvtok_pkg::CH_NUL);
    send_line();
    drain();

    // One field per row: too many fields at a comma and at the end byte.
    write_reg(csvtok_pkg::ADDR_COLUMN_LIMIT, 1);
    push_text("a,b,c");
    line_q.push_back(csvtok_pkg::CH_NUL);
    push_text("d,e");
    line_q.push_back(csvtok_pkg::CH_NUL);
    send_line();
    drain();

    // Long receiver hold while content words keep coming.
    write_reg(csvtok_pkg::ADDR_COLUMN_LIMIT, csvtok_pkg::MAX_COLUMNS);
    hold_request = 1;
    repeat (40) line_q.push_back(pick_char(0));
    line_q.push_back(csvtok_pkg::CH_NUL);
    send_line();
    drain();

    // Random rows under several column limits and idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: cols = 3;
        2: cols = 1;
        4: cols = 2;
        5: cols = 7;
        6: cols = $urandom_range(1, csvtok_pkg::MAX_COLUMNS);
        default: cols = csvtok_pkg::MAX_COLUMNS;
      endcase
      write_reg(csvtok_pkg::ADDR_COLUMN_LIMIT, cols);
      case (p % 4)
        1: begin
          send_idle_pct = 86;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 86;
        end
        3: begin
          send_idle_pct = 7;
          stall_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      goal = board.live_chars + PHASE_CHARS;
      while (board.live_chars < goal) begin
        case ($urandom_range(15))
          0, 1: build_noise();
          2: begin
            line_q.push_back(csvtok_pkg::CH_QUOTE);
            repeat ($urandom_range(4)) line_q.push_back(pick_char(1));
            line_q.push_back(csvtok_pkg::CH_NUL);
          end
          default: build_row(cols);
        endcase
        send_line();
      end
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);

    if (board.pending_tokens.size() != 0) begin
      $error("%0d expected results never arrived", board.pending_tokens.size());
      board.failures++;
    end
    $display("Sent %0d characters (%0d in open rows): directed cases, a long output hold,",
             board.all_chars, board.live_chars);
    $display("column limits 1 to 64, idle and stall phases; checked %0d bytes, %0d %s",
             board.kinds_seen[csvtok_pkg::KIND_BYTE], board.kinds_seen[csvtok_pkg::KIND_FIELD],
             $sformatf("field ends, %0d dropped fields, %0d errors",
                       board.kinds_seen[csvtok_pkg::KIND_ROW],
                       board.kinds_seen[csvtok_pkg::KIND_ERROR]));
    if (board.failures == 0) begin
      $display("csv_field_tokenizer test passed");
    end else begin
      $display("csv_field_tokenizer test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/csvtok_pkg.sv
src/csv_field_tokenizer.sv
test/csv_field_tokenizer_test.sv
